@@ rtl/wpm_pkg.sv @@
// ----------------------------------------------------------------------------
// wpm_pkg: shared types and constants for the wildcard pattern matcher
// Payload structs, register indexes, wildcard codes and the link between
// neighboring match cells.
// ----------------------------------------------------------------------------
package wpm_pkg;

   localparam int CHAR_W        = 8;   // pattern bytes and text characters
   localparam int PAT_REG_W     = 64;  // one pattern character register
   localparam int PAT_BYTES_MAX = 16;  // characters held by both registers
   localparam int LEN_REG_W     = 5;
   localparam int CSR_IDX_W     = 2;

   localparam int MAX_PATTERN_CHARS_DEF = 16;
   localparam int CHAR_BITS_DEF         = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LEN  = 2'd2;

   localparam logic [CHAR_W-1:0] ANY_ONE = 8'h3F;  // '?'
   localparam logic [CHAR_W-1:0] ANY_RUN = 8'h2A;  // '*'

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              char_present;
      logic              end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic matched;
      logic string_done;
   } rsp_payload_type;

   // Signals handed from one cell to the next position up
   typedef struct packed {
      logic advance;   // position moves forward on this character
      logic closure;   // reached across a star from below
      logic start;     // part of the start set
   } chain_link_type;

   // Update command broadcast to every cell
   typedef struct packed {
      logic load_start;
      logic load_next;
   } cell_ctrl_type;

endpackage

@@ rtl/wpm_cell.sv @@
// ----------------------------------------------------------------------------
// wpm_cell: one pattern position of the matcher chain
// Holds the active bit of its position, compares its pattern character with
// the text character and passes advance, star closure and start set upward.
// ----------------------------------------------------------------------------
module wpm_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        reset_value,
   input  logic [wpm_pkg::CHAR_W-1:0]  pattern_char,
   input  logic                        in_use,
   input  logic [wpm_pkg::CHAR_W-1:0]  text_char,
   input  wpm_pkg::cell_ctrl_type      ctrl,
   input  wpm_pkg::chain_link_type     link_in,
   output wpm_pkg::chain_link_type     link_out,
   output logic                        active,
   output logic                        closed
);
   import wpm_pkg::*;

   logic act_ff;
   logic act_in;
   logic is_star;
   logic is_any;
   logic is_equal;
   logic pre_closure;

   assign is_star  = in_use && (pattern_char == ANY_RUN);
   assign is_any   = (pattern_char == ANY_ONE);
   assign is_equal = (pattern_char == text_char);

   // a star keeps its own position alive, anything else hands it forward
   assign pre_closure = (act_ff & is_star) | link_in.advance;
   assign closed      = pre_closure | link_in.closure;

   assign link_out.advance = act_ff & in_use & ~is_star & (is_any | is_equal);
   assign link_out.closure = closed & is_star;
   assign link_out.start   = link_in.start & is_star;

   assign active = act_ff;

   always_comb begin
      act_in = act_ff;
      if (ctrl.load_start) begin
         act_in = link_in.start;
      end else if (ctrl.load_next) begin
         act_in = closed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= reset_value;
      end else begin
         act_ff <= act_in;
      end
   end

endmodule

@@ rtl/wildcard_pattern_matcher.sv @@
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher: streaming wildcard pattern matcher
// Matches text characters against a configured pattern with '?' and '*'.
// ----------------------------------------------------------------------------
// Each accepted transaction yields one response in the next cycle; a new
// transaction is taken every cycle while the response register is empty or
// being drained. The per-character update is a row of position cells, one
// per pattern character plus the end position; the star closure ripples
// through the row within the cycle, so its length (MAX_PATTERN_CHARS) sets
// the clock path. Any register write restarts the string in progress, as
// does a transaction with end_of_text set once its verdict is produced. The
// cycle after a register write, req_ready is held low while the row loads
// the start set of the new pattern.
// The csr port must be written only while no transaction is in flight.
module wildcard_pattern_matcher #(
   parameter int MAX_PATTERN_CHARS = wpm_pkg::MAX_PATTERN_CHARS_DEF,
   parameter int CHAR_BITS         = wpm_pkg::CHAR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  wpm_pkg::req_payload_type          req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output wpm_pkg::rsp_payload_type          rsp_data,
   input  logic                              csr_we,
   input  logic [wpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wpm_pkg::PAT_REG_W-1:0]     csr_wdata
);
   import wpm_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN_CHARS + 1);
   localparam logic [CHAR_W-1:0] CHAR_MASK =
      (CHAR_BITS >= CHAR_W) ? {CHAR_W{1'b1}} : CHAR_W'((1 << CHAR_BITS) - 1);

   logic [PAT_REG_W-1:0]        pat_low_ff;
   logic [PAT_REG_W-1:0]        pat_high_ff;
   logic [LEN_REG_W-1:0]        pat_len_ff;
   logic [2*PAT_REG_W-1:0]      pat_all;
   logic [LEN_W-1:0]            len_eff;
   logic [CHAR_W-1:0]           text_masked;

   logic                        req_accept;
   logic                        csr_hit;
   logic                        restart_ff;
   logic                        restart_in;
   cell_ctrl_type               ctrl;

   chain_link_type              link [0:MAX_PATTERN_CHARS];
   logic [MAX_PATTERN_CHARS:0]  active_vec;
   logic [MAX_PATTERN_CHARS:0]  closed_vec;

   logic                        end_act_ff;
   logic                        end_act_in;
   logic                        matched_now;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   rsp_payload_type             rsp_data_ff;
   rsp_payload_type             rsp_data_in;

   // ---------------- configuration registers ----------------
   assign csr_hit = csr_we && ((csr_index == CSR_PAT_LOW) || (csr_index == CSR_PAT_HIGH) ||
                               (csr_index == CSR_PAT_LEN));

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAT_LOW:  pat_low_ff  <= csr_wdata;
            CSR_PAT_HIGH: pat_high_ff <= csr_wdata;
            CSR_PAT_LEN:  pat_len_ff  <= csr_wdata[LEN_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // reload the start set once the new pattern sits in the registers
   assign restart_in = csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff <= 1'b0;
      end else begin
         restart_ff <= restart_in;
      end
   end

   assign pat_all = {pat_high_ff, pat_low_ff};

   // clamp an oversized length to the cell count
   always_comb begin
      if (pat_len_ff > LEN_REG_W'(MAX_PATTERN_CHARS)) begin
         len_eff = LEN_W'(MAX_PATTERN_CHARS);
      end else begin
         len_eff = pat_len_ff[LEN_W-1:0];
      end
   end

   assign text_masked = req_data.text_char & CHAR_MASK;

   // ---------------- cell row ----------------
   assign req_accept      = req_valid & req_ready;
   assign ctrl.load_start = restart_ff | (req_accept & req_data.end_of_text);
   assign ctrl.load_next  = req_accept & req_data.char_present;

   assign link[0].advance = 1'b0;
   assign link[0].closure = 1'b0;
   assign link[0].start   = 1'b1;

   for (genvar k = 0; k < MAX_PATTERN_CHARS; k++) begin : g_cell
      wpm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .reset_value  ((k == 0) ? 1'b1 : 1'b0),
         .pattern_char (pat_all[CHAR_W*k +: CHAR_W]),
         .in_use       (len_eff > LEN_W'(k)),
         .text_char    (text_masked),
         .ctrl         (ctrl),
         .link_in      (link[k]),
         .link_out     (link[k+1]),
         .active       (active_vec[k]),
         .closed       (closed_vec[k])
      );
   end

   // end position past the last cell: reached by advance, closure or the start set
   assign active_vec[MAX_PATTERN_CHARS] = end_act_ff;
   assign closed_vec[MAX_PATTERN_CHARS] = link[MAX_PATTERN_CHARS].advance |
                                          link[MAX_PATTERN_CHARS].closure;

   always_comb begin
      end_act_in = end_act_ff;
      if (ctrl.load_start) begin
         end_act_in = link[MAX_PATTERN_CHARS].start;
      end else if (ctrl.load_next) begin
         end_act_in = closed_vec[MAX_PATTERN_CHARS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_act_ff <= 1'b0;
      end else begin
         end_act_ff <= end_act_in;
      end
   end

   assign matched_now = req_data.char_present ? closed_vec[len_eff] : active_vec[len_eff];

   // ---------------- response register ----------------
   assign req_ready = ~restart_ff & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.matched     = matched_now;
         rsp_data_in.string_done = req_data.end_of_text;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
